@@ rtl/core/diff_drive_wheel_speeds_assert.svh @@
// Assertion macros for the differential-drive wheel speed block.
`ifndef DIFF_DRIVE_WHEEL_SPEEDS_ASSERT_SVH
`define DIFF_DRIVE_WHEEL_SPEEDS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DDWS_ASSERT_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("ddws: implication check failed");

// Implication after a fixed number of cycles, disabled during reset.
`define DDWS_ASSERT_DELAY(label, clk, rst_n, a, lat, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##(lat) (c)) \
		else $error("ddws: latency check failed");

`endif

@@ rtl/core/ddws_pkg.sv @@
// Types and constants for the differential-drive wheel speed block.
package ddws_pkg;

	localparam int FUNC_W   = 3;
	localparam int SPEED_W  = 16;
	localparam int RADIUS_W = 19;
	localparam int OUT_W    = 20;
	localparam int MAXS_W   = 15;
	localparam int TRACK_W  = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int OUT_MAX = 524287;
	localparam int OUT_MIN = -524288;

	// Drive command codes
	localparam logic [FUNC_W-1:0] FN_STOP      = 3'd0;
	localparam logic [FUNC_W-1:0] FN_FORWARD   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_BACKWARD  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_PIVOT_CW  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_PIVOT_CCW = 3'd4;
	localparam logic [FUNC_W-1:0] FN_ARC_R     = 3'd5;
	localparam logic [FUNC_W-1:0] FN_ARC_L     = 3'd6;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED = 2'd2;

	localparam logic [MAXS_W-1:0]  MAX_SPEED_RST  = 15'd1000;
	localparam logic [TRACK_W-1:0] TRACK_RST      = 12'd150;
	localparam logic [MAXS_W-1:0]  TURN_SPEED_RST = 15'd200;

endpackage

@@ rtl/core/diff_drive_wheel_speeds.sv @@
// Differential-drive wheel speed pipeline: decode, arc products, two dividers, output.
//
// One drive command is taken per clock and its wheel speeds appear on the
// result ports (strobe high one cycle). Two restoring dividers resolve one
// quotient bit per pipeline stage over 16 + FRAC_BITS stages; four stages
// of decode and multiply come before them and one output register after.
// busy never rises. Configuration writes are always ready and are to be
// made only while no command is in flight.
module diff_drive_wheel_speeds #(
	parameter int FRAC_BITS = 4
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [ddws_pkg::FUNC_W-1:0]            func,
	input  logic signed [ddws_pkg::SPEED_W-1:0]    speed,
	input  logic signed [ddws_pkg::RADIUS_W-1:0]   radius,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ddws_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ddws_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic                                   strobe,
	output logic                                   stop_motors,
	output logic signed [ddws_pkg::OUT_W-1:0]      left_speed,
	output logic signed [ddws_pkg::OUT_W-1:0]      right_speed
);
	import ddws_pkg::*;

	localparam int QW   = 16 + FRAC_BITS;         // quotient bits
	localparam int MAGW = MAXS_W + FRAC_BITS;     // straight-line magnitude
	localparam int DW   = RADIUS_W;               // divisor / remainder bits
	localparam int PW   = 34;                     // 15 x 19 product
	localparam int XW   = (QW + 3 > OUT_W + 1) ? QW + 3 : OUT_W + 1;
	localparam int LAT  = QW + 5;

	typedef struct packed {
		logic [FUNC_W-1:0] fn;
		logic [MAGW-1:0]   mag;
		logic              ineg;
		logic [DW-1:0]     den;
	} side_t;

	// Configuration registers
	logic [MAXS_W-1:0]  max_speed_q;
	logic [TRACK_W-1:0] track_q;
	logic [MAXS_W-1:0]  turn_speed_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q  <= MAX_SPEED_RST;
			track_q      <= TRACK_RST;
			turn_speed_q <= TURN_SPEED_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_SPEED:  max_speed_q  <= cfg_data[MAXS_W-1:0];
				REG_TRACK:      track_q      <= cfg_data[TRACK_W-1:0];
				REG_TURN_SPEED: turn_speed_q <= cfg_data[MAXS_W-1:0];
				default:        ;
			endcase
		end
	end

	// Stage 1: magnitudes, small-radius fallback to pivot
	logic [SPEED_W-1:0]  spd_abs;
	logic [DW-1:0]       rad_abs;
	logic                is_arc;
	logic                small_rad;
	logic [FUNC_W-1:0]   fn_in;
	logic [SPEED_W-1:0]  spd_in;

	always_comb begin
		spd_abs   = speed[SPEED_W-1] ? SPEED_W'(-speed) : SPEED_W'(speed);
		rad_abs   = radius[RADIUS_W-1] ? DW'(-radius) : DW'(radius);
		is_arc    = (func == FN_ARC_R) || (func == FN_ARC_L);
		small_rad = rad_abs < DW'(4);
		fn_in     = func;
		spd_in    = spd_abs;
		if (is_arc && small_rad) begin
			fn_in  = (func == FN_ARC_R) ? FN_PIVOT_CW : FN_PIVOT_CCW;
			spd_in = SPEED_W'(turn_speed_q);
		end
	end

	logic                vld_s1;
	logic [FUNC_W-1:0]   fn_s1;
	logic [SPEED_W-1:0]  spd_s1;
	logic [DW-1:0]       rad_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		fn_s1  <= fn_in;
		spd_s1 <= spd_in;
		rad_s1 <= rad_abs;
	end

	// Stage 2: clamp straight speed, r +/- 2*track, scale test products
	logic [MAXS_W-1:0]     mag_c;
	logic [TRACK_W:0]      half_trk;
	logic                  vld_s2;
	logic [FUNC_W-1:0]     fn_s2;
	logic [MAGW-1:0]       mag_s2;
	logic [DW-1:0]         rad_s2;
	logic [DW-1:0]         rp_s2;
	logic signed [DW:0]    rm_s2;
	logic [PW-1:0]         pts_s2;
	logic [PW-1:0]         pmx_s2;

	always_comb begin
		mag_c    = (spd_s1 > SPEED_W'(max_speed_q)) ? max_speed_q : spd_s1[MAXS_W-1:0];
		half_trk = {track_q, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		fn_s2  <= fn_s1;
		mag_s2 <= MAGW'(mag_c) << FRAC_BITS;
		rad_s2 <= rad_s1;
		rp_s2  <= rad_s1 + DW'(half_trk);
		rm_s2  <= $signed((DW+1)'(rad_s1) - (DW+1)'(half_trk));
		pts_s2 <= PW'(turn_speed_q) * PW'(rad_s1 + DW'(half_trk));
		pmx_s2 <= PW'(max_speed_q) * PW'(rad_s1);
	end

	// Stage 3: pick scale factor and divisor
	logic                vld_s3;
	logic [FUNC_W-1:0]   fn_s3;
	logic [MAGW-1:0]     mag_s3;
	logic [MAXS_W-1:0]   k_s3;
	logic [DW-1:0]       den_s3;
	logic [DW-1:0]       no_s3;
	logic [DW-1:0]       ni_s3;
	logic                ineg_s3;
	logic                scaled;

	assign scaled = pts_s2 > pmx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		fn_s3   <= fn_s2;
		mag_s3  <= mag_s2;
		k_s3    <= scaled ? max_speed_q : turn_speed_q;
		den_s3  <= scaled ? rp_s2 : rad_s2;
		no_s3   <= rp_s2;
		ni_s3   <= rm_s2[DW] ? DW'(-rm_s2) : DW'(rm_s2);
		ineg_s3 <= rm_s2[DW];
	end

	// Stage 4: numerator products
	logic              vld_s4;
	side_t             side_s4;
	logic [PW-1:0]     nop_s4;
	logic [PW-1:0]     nip_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		side_s4.fn   <= fn_s3;
		side_s4.mag  <= mag_s3;
		side_s4.ineg <= ineg_s3;
		side_s4.den  <= den_s3;
		nop_s4       <= PW'(k_s3) * PW'(no_s3);
		nip_s4       <= PW'(k_s3) * PW'(ni_s3);
	end

	// Divider entry: numerator is product << FRAC_BITS; top bits start the remainder
	logic [DW-1:0] rem_o0, rem_i0;
	logic [QW-1:0] nq_o0, nq_i0;

	assign rem_o0 = DW'(nop_s4[PW-1:16]);
	assign rem_i0 = DW'(nip_s4[PW-1:16]);
	assign nq_o0  = QW'(nop_s4[15:0]) << FRAC_BITS;
	assign nq_i0  = QW'(nip_s4[15:0]) << FRAC_BITS;

	// Divider stages: one quotient bit per stage for both lanes
	logic          dvld_s  [1:QW];
	side_t         dside_s [1:QW];
	logic [DW-1:0] drem_o_s[1:QW];
	logic [DW-1:0] drem_i_s[1:QW];
	logic [QW-1:0] dnq_o_s [1:QW];
	logic [QW-1:0] dnq_i_s [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic          pv;
		side_t         ps;
		logic [DW-1:0] pro, pri;
		logic [QW-1:0] pqo, pqi;
		logic [DW:0]   to, ti;
		logic          geo, gei;

		if (k == 0) begin : g_first
			assign pv  = vld_s4;
			assign ps  = side_s4;
			assign pro = rem_o0;
			assign pri = rem_i0;
			assign pqo = nq_o0;
			assign pqi = nq_i0;
		end else begin : g_next
			assign pv  = dvld_s[k];
			assign ps  = dside_s[k];
			assign pro = drem_o_s[k];
			assign pri = drem_i_s[k];
			assign pqo = dnq_o_s[k];
			assign pqi = dnq_i_s[k];
		end

		assign to  = {pro, pqo[QW-1]};
		assign ti  = {pri, pqi[QW-1]};
		assign geo = to >= {1'b0, ps.den};
		assign gei = ti >= {1'b0, ps.den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dvld_s[k+1] <= 1'b0;
			else         dvld_s[k+1] <= pv;
		end

		always_ff @(posedge clk) begin
			dside_s[k+1]  <= ps;
			drem_o_s[k+1] <= geo ? DW'(to - {1'b0, ps.den}) : DW'(to);
			drem_i_s[k+1] <= gei ? DW'(ti - {1'b0, ps.den}) : DW'(ti);
			dnq_o_s[k+1]  <= {pqo[QW-2:0], geo};
			dnq_i_s[k+1]  <= {pqi[QW-2:0], gei};
		end
	end

	// Output: round half away from zero, assign wheels, negate left, saturate
	side_t              fs;
	logic signed [XW-1:0] outer, inner, mag_x, lft, rgt;
	logic               stop_c;

	function automatic logic signed [OUT_W-1:0] sat(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] hi, lo;
		hi = $signed(XW'(OUT_MAX));
		lo = $signed(XW'(OUT_MIN));
		if (v > hi)      sat = OUT_W'(hi);
		else if (v < lo) sat = OUT_W'(lo);
		else             sat = OUT_W'(v);
	endfunction

	always_comb begin
		fs     = dside_s[QW];
		outer  = $signed(XW'(dnq_o_s[QW]) +
			XW'({drem_o_s[QW], 1'b0} >= {1'b0, fs.den}));
		inner  = $signed(XW'(dnq_i_s[QW]) +
			XW'({drem_i_s[QW], 1'b0} >= {1'b0, fs.den}));
		if (fs.ineg) inner = -inner;
		mag_x  = $signed(XW'(fs.mag));
		lft    = '0;
		rgt    = '0;
		stop_c = 1'b0;
		case (fs.fn)
			FN_FORWARD:   begin lft = mag_x;  rgt = mag_x;  end
			FN_BACKWARD:  begin lft = -mag_x; rgt = -mag_x; end
			FN_PIVOT_CW:  begin lft = mag_x;  rgt = -mag_x; end
			FN_PIVOT_CCW: begin lft = -mag_x; rgt = mag_x;  end
			FN_ARC_R:     begin lft = outer;  rgt = inner;  end
			FN_ARC_L:     begin lft = inner;  rgt = outer;  end
			default:      stop_c = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else         strobe <= dvld_s[QW];
	end

	always_ff @(posedge clk) begin
		stop_motors <= stop_c;
		left_speed  <= sat(-lft);
		right_speed <= sat(rgt);
	end

	// Checks
	`include "diff_drive_wheel_speeds_assert.svh"

	`DDWS_ASSERT_DELAY(a_latency, clk, arst_n, start && !busy, LAT, strobe)
	`DDWS_ASSERT_IMPLY(a_stop_zero, clk, arst_n, strobe && stop_motors, left_speed == '0 && right_speed == '0)
	`DDWS_ASSERT_IMPLY(a_strobe_src, clk, arst_n, strobe, $past(start, LAT))

endmodule
